// ===== rtl/uiec_pkg.sv =====
`timescale 1ns / 1ps

package uiec_pkg;

	// Item kinds on the request channel.
	localparam logic REQ_DESC = 1'b0;
	localparam logic REQ_WORD = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_CAPTURE_ENABLE = 1'b0;
	localparam logic CFG_CAPTURE_MASK   = 1'b1;

	// Protocol numbers and fixed header values.
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
	localparam logic [7:0]  HOP_LIMIT    = 8'd64;
	localparam logic [15:0] IP4_VER_IHL  = 16'h4500;
	localparam logic [15:0] NO_ZERO_SUM  = 16'hffff;

	// Header sizes in bytes.
	localparam logic [16:0] IP4_HDR_BYTES = 17'd20;
	localparam logic [16:0] IP6_HDR_BYTES = 17'd40;
	localparam logic [16:0] UDP_HDR_BYTES = 17'd8;

	typedef struct packed {
		logic        req_type;
		logic [15:0] kind_bits;
		logic        is_ipv6;
		logic        is_icmp;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_len;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [15:0] payload_word;
	} uiec_in_t;

	typedef struct packed {
		logic        dropped;
		logic [15:0] ip_checksum;
		logic [15:0] l4_checksum;
		logic [15:0] ip_length;
		logic [15:0] udp_length;
		logic [7:0]  ip_protocol;
		logic [16:0] record_length;
		logic [31:0] record_number;
	} uiec_out_t;

	// Plain sum of the eight 16-bit words of a 128-bit value.
	function automatic logic [18:0] word_sum8(input logic [127:0] v);
		logic [18:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + {3'b000, v[i*16 +: 16]};
		end
		return acc;
	endfunction

	// Fold a plain sum into a 16-bit one's-complement sum with end-around carry.
	// A nonzero input never folds to zero.
	function automatic logic [15:0] csum_fold21(input logic [20:0] x);
		logic [16:0] t;
		t = {1'b0, x[15:0]} + {12'b0, x[20:16]};
		return t[15:0] + {15'b0, t[16]};
	endfunction

	// One's-complement add of two 16-bit values.
	function automatic logic [15:0] csum_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'b0, t[16]};
	endfunction

endpackage

// ===== rtl/udp_ip_encap_checksum.sv =====
`timescale 1ns / 1ps

// A result passes the input register, stages 2 and 3 and the output register before it is valid.
// One item per cycle unless stalled; each payload word is one end-around-carry add to the sum.
// The request side stalls only while a finished result waits in the output register.
// Reset clears the configuration, the in-packet flag, the record counter and all valid flags.
module udp_ip_encap_checksum
	import uiec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  uiec_in_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output uiec_out_t   rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic        cap_en_q;
	logic [15:0] cap_mask_q;

	// Pipeline stages.
	logic        vld_s1;
	uiec_in_t    req_s1;

	logic        vld_s2, type_s2, v6_s2, icmp_s2, odd_s2, keep_s2;
	logic [15:0] words_s2, udplen_s2, iplen_s2, sport_s2, dport_s2, word_s2;
	logic [7:0]  proto_s2;
	logic [16:0] record_s2;
	logic [18:0] src_sum_s2, dst_sum_s2;
	logic [31:0] sa_s2, da_s2;

	logic        vld_s3, type_s3, icmp_s3, odd_s3, keep_s3;
	logic [15:0] words_s3, udplen_s3, iplen_s3, word_s3, pseudo_s3, ipsum_s3;
	logic [7:0]  proto_s3;
	logic [16:0] record_s3;

	// Packet state.
	logic        in_packet_q;
	logic [15:0] run_sum_q;
	logic [15:0] words_left_q;
	logic [1:0]  word_idx_q;
	logic        odd_q, zero_w1_q;
	logic [15:0] ipsum_q, iplen_q, udplen_q;
	logic [7:0]  proto_q;
	logic [16:0] record_q;
	logic [31:0] pkt_count_q;

	logic      out_valid_q;
	uiec_out_t out_q;

	// The whole pipeline moves unless a result waits and is stalled.
	logic adv;
	assign adv       = !out_valid_q || !rsp_stall;
	assign req_stall = !adv;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q   <= 1'b0;
			cap_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAPTURE_ENABLE: cap_en_q   <= cfg_data[0];
				CFG_CAPTURE_MASK:   cap_mask_q <= cfg_data;
				default:            cap_en_q   <= cap_en_q;
			endcase
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req_valid) begin
			req_s1 <= req;
		end
	end

	// Stage 2: header fields, lengths, filter decision and address word sums.
	logic [16:0]  len17, l4len17;
	logic [15:0]  l4len16;
	logic [127:0] src_words, dst_words;
	logic         use_v4_addr;

	always_comb begin
		len17       = {1'b0, req_s1.payload_len};
		l4len17     = req_s1.is_icmp ? len17 : len17 + UDP_HDR_BYTES;
		l4len16     = l4len17[15:0];
		use_v4_addr = !req_s1.is_ipv6 && !req_s1.is_icmp;
		if (req_s1.is_ipv6) begin
			src_words = {req_s1.src_addr_hi, req_s1.src_addr_lo};
			dst_words = {req_s1.dst_addr_hi, req_s1.dst_addr_lo};
		end else if (use_v4_addr) begin
			src_words = {96'b0, req_s1.src_addr_lo[31:0]};
			dst_words = {96'b0, req_s1.dst_addr_lo[31:0]};
		end else begin
			src_words = '0;
			dst_words = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			type_s2    <= req_s1.req_type;
			v6_s2      <= req_s1.is_ipv6;
			icmp_s2    <= req_s1.is_icmp;
			odd_s2     <= req_s1.payload_len[0];
			keep_s2    <= cap_en_q && ((req_s1.kind_bits & cap_mask_q) != 16'd0);
			words_s2   <= 16'((len17 + 17'd1) >> 1);
			udplen_s2  <= req_s1.is_icmp ? 16'd0 : l4len16;
			iplen_s2   <= req_s1.is_ipv6 ? l4len16 : l4len16 + IP4_HDR_BYTES[15:0];
			proto_s2   <= req_s1.is_icmp ? (req_s1.is_ipv6 ? PROTO_ICMPV6 : PROTO_ICMP)
			                             : PROTO_UDP;
			record_s2  <= (req_s1.is_ipv6 ? IP6_HDR_BYTES : IP4_HDR_BYTES)
			              + (req_s1.is_icmp ? 17'd0 : UDP_HDR_BYTES) + len17;
			sport_s2   <= req_s1.src_port;
			dport_s2   <= req_s1.dst_port;
			word_s2    <= req_s1.payload_word;
			src_sum_s2 <= word_sum8(src_words);
			dst_sum_s2 <= word_sum8(dst_words);
			sa_s2      <= req_s1.src_addr_lo[31:0];
			da_s2      <= req_s1.dst_addr_lo[31:0];
		end
	end

	// Stage 3: pseudoheader sum and IPv4 header checksum.
	logic [18:0] misc_sum, hdr_sum;
	logic [20:0] total_sum;
	logic [15:0] l4len_s2;

	always_comb begin
		l4len_s2 = v6_s2 ? iplen_s2 : udplen_s2;
		misc_sum = '0;
		if (v6_s2 || !icmp_s2) begin
			misc_sum = {11'b0, proto_s2} + {3'b0, l4len_s2};
			if (!icmp_s2) begin
				misc_sum = misc_sum + {3'b0, sport_s2} + {3'b0, dport_s2}
				           + {3'b0, udplen_s2};
			end
		end
		total_sum = {2'b00, src_sum_s2} + {2'b00, dst_sum_s2} + {2'b00, misc_sum};
		hdr_sum = {3'b0, IP4_VER_IHL} + {3'b0, iplen_s2} + {3'b0, HOP_LIMIT, proto_s2}
		          + {3'b0, sa_s2[31:16]} + {3'b0, sa_s2[15:0]}
		          + {3'b0, da_s2[31:16]} + {3'b0, da_s2[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			type_s3   <= type_s2;
			icmp_s3   <= icmp_s2;
			odd_s3    <= odd_s2;
			keep_s3   <= keep_s2;
			words_s3  <= words_s2;
			udplen_s3 <= udplen_s2;
			iplen_s3  <= iplen_s2;
			proto_s3  <= proto_s2;
			record_s3 <= record_s2;
			word_s3   <= word_s2;
			pseudo_s3 <= csum_fold21(total_sum);
			ipsum_s3  <= v6_s2 ? 16'd0 : ~csum_fold21({2'b00, hdr_sum});
		end
	end

	// Commit: packet state update and result generation.
	logic [15:0] word_m, sum_next, csum_c, l4_out;
	logic        emit, emit_drop;
	uiec_out_t   drop_rec;

	always_comb begin
		word_m = word_s3;
		if (words_left_q == 16'd1 && odd_q) begin
			word_m = word_m & 16'hff00;
		end
		if (zero_w1_q && word_idx_q == 2'd1) begin
			word_m = 16'd0;
		end
		sum_next  = (type_s3 == REQ_DESC) ? pseudo_s3 : csum_add16(run_sum_q, word_m);
		csum_c    = ~sum_next;
		l4_out    = (csum_c == 16'd0) ? NO_ZERO_SUM : csum_c;
		emit_drop = vld_s3 && type_s3 == REQ_DESC && !keep_s3;
		emit      = vld_s3 && (((type_s3 == REQ_DESC) && keep_s3 && words_s3 == 16'd0)
		            || ((type_s3 == REQ_WORD) && in_packet_q && words_left_q == 16'd1));
		drop_rec         = '0;
		drop_rec.dropped = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			pkt_count_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit || emit_drop;
			if (emit) begin
				pkt_count_q <= pkt_count_q + 32'd1;
			end
			if (vld_s3) begin
				if (type_s3 == REQ_DESC) begin
					in_packet_q <= keep_s3 && words_s3 != 16'd0;
				end else if (in_packet_q && words_left_q == 16'd1) begin
					in_packet_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			if (type_s3 == REQ_DESC) begin
				run_sum_q    <= pseudo_s3;
				words_left_q <= words_s3;
				word_idx_q   <= 2'd0;
				odd_q        <= odd_s3;
				zero_w1_q    <= icmp_s3;
				ipsum_q      <= ipsum_s3;
				iplen_q      <= iplen_s3;
				udplen_q     <= udplen_s3;
				proto_q      <= proto_s3;
				record_q     <= record_s3;
			end else if (in_packet_q) begin
				run_sum_q    <= sum_next;
				words_left_q <= words_left_q - 16'd1;
				if (word_idx_q != 2'd2) begin
					word_idx_q <= word_idx_q + 2'd1;
				end
			end
		end
	end

	// Output register; a descriptor that finishes at once reports its own fields.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (emit_drop) begin
				out_q <= drop_rec;
			end else if (emit) begin
				out_q.dropped       <= 1'b0;
				out_q.l4_checksum   <= l4_out;
				out_q.record_number <= pkt_count_q + 32'd1;
				if (type_s3 == REQ_DESC) begin
					out_q.ip_checksum   <= ipsum_s3;
					out_q.ip_length     <= iplen_s3;
					out_q.udp_length    <= udplen_s3;
					out_q.ip_protocol   <= proto_s3;
					out_q.record_length <= record_s3;
				end else begin
					out_q.ip_checksum   <= ipsum_q;
					out_q.ip_length     <= iplen_q;
					out_q.udp_length    <= udplen_q;
					out_q.ip_protocol   <= proto_q;
					out_q.record_length <= record_q;
				end
			end
		end
	end

	// A dropped packet reports nothing but the drop flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dropped |->
			out_q.record_number == 32'd0 && out_q.l4_checksum == 16'd0
			&& out_q.record_length == 17'd0)
		else $error("dropped result carries nonzero fields");

	// A sent L4 checksum is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.dropped |-> out_q.l4_checksum != 16'd0)
		else $error("zero L4 checksum sent");

	// The record counter matches the number of the waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.dropped |-> out_q.record_number == pkt_count_q)
		else $error("record number out of step with counter");

	// A packet in progress always expects at least one more word.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_packet_q |-> words_left_q != 16'd0)
		else $error("packet open with no words left");

	// The request side stalls only behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> out_valid_q && rsp_stall)
		else $error("request stalled without a waiting result");

endmodule
